FILE: sv/iso8601_pkg.sv
// Shared types, constants and calendar tables for the ISO 8601 timestamp converter.
// Used by the interfaces, the character parser, the queue and the epoch engine.
// Depends on nothing.
package iso8601_pkg;

	localparam int YEAR_W  = 14;
	localparam int FIELD_W = 7;
	localparam int MILLI_W = 10;
	localparam int MS_W    = 48;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MAX = 2'd1;

	localparam logic [YEAR_W-1:0] YEAR_MIN_RST = 14'd2024;
	localparam logic [YEAR_W-1:0] YEAR_MAX_RST = 14'd2100;
	localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 14'd1970;

	// Gathered fields of one string, handed from parser to epoch engine
	typedef struct packed {
		logic                fmt_ok;
		logic [YEAR_W-1:0]   year;
		logic [FIELD_W-1:0]  month;
		logic [FIELD_W-1:0]  day;
		logic [FIELD_W-1:0]  hour;
		logic [FIELD_W-1:0]  minute;
		logic [FIELD_W-1:0]  second;
		logic [MILLI_W-1:0]  milli;
	} job_t;

	// Epoch engine sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_DOE,
		ST_DAYS,
		ST_SECS,
		ST_MS
	} back_state_t;

	// Days in month m (1..12); February follows the leap flag
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		begin
			unique case (m)
				4'd2: n = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
				default: n = 5'd31;
			endcase
			return n;
		end
	endfunction

	// Day of year at the start of month index mp, with March as index 0
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] n;
		begin
			unique case (mp)
				4'd0:  n = 9'd0;
				4'd1:  n = 9'd31;
				4'd2:  n = 9'd61;
				4'd3:  n = 9'd92;
				4'd4:  n = 9'd122;
				4'd5:  n = 9'd153;
				4'd6:  n = 9'd184;
				4'd7:  n = 9'd214;
				4'd8:  n = 9'd245;
				4'd9:  n = 9'd275;
				4'd10: n = 9'd306;
				4'd11: n = 9'd337;
				default: n = 9'd0;
			endcase
			return n;
		end
	endfunction

endpackage

FILE: sv/iso8601_if.sv
// Valid/ready channel interfaces: character input, result output, configuration write.
// Depends on iso8601_pkg for field widths.

interface iso8601_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

interface iso8601_res_if;
	logic                          valid;
	logic                          ready;
	logic                          valid_res;
	logic [iso8601_pkg::MS_W-1:0]  epoch_ms;

	modport source (output valid, output valid_res, output epoch_ms, input ready);
	modport sink   (input valid, input valid_res, input epoch_ms, output ready);
endinterface

interface iso8601_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [iso8601_pkg::CFG_IDX_W-1:0]  index;
	logic [iso8601_pkg::YEAR_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/iso8601_front.sv
// Character parser: checks the layout of each string and gathers its numeric fields.
// Depends on iso8601_pkg and iso8601_char_if; pushes one job per string.
module iso8601_front (
	input  logic                 clk,
	input  logic                 arst_n,
	iso8601_char_if.sink         chars,
	output logic                 job_valid,
	input  logic                 job_ready,
	output iso8601_pkg::job_t    job
);

	localparam logic [4:0] POS_DASH1  = 5'd4;
	localparam logic [4:0] POS_DASH2  = 5'd7;
	localparam logic [4:0] POS_T      = 5'd10;
	localparam logic [4:0] POS_COLON1 = 5'd13;
	localparam logic [4:0] POS_COLON2 = 5'd16;
	localparam logic [4:0] POS_DOT    = 5'd19;
	localparam logic [4:0] POS_Z      = 5'd23;
	localparam logic [4:0] POS_LEN    = 5'd24;
	localparam logic [4:0] POS_SAT    = 5'd25;

	logic [4:0]                            pos_q;
	logic                                  err_q;
	logic [iso8601_pkg::YEAR_W-1:0]        year_q;
	logic [iso8601_pkg::FIELD_W-1:0]       month_q, day_q, hour_q, minute_q, second_q;
	logic [iso8601_pkg::MILLI_W-1:0]       milli_q;

	logic                                  is_digit;
	logic [3:0]                            dv;
	logic                                  err_d;
	logic [4:0]                            pos_d;
	logic [iso8601_pkg::YEAR_W-1:0]        year_d;
	logic [iso8601_pkg::FIELD_W-1:0]       month_d, day_d, hour_d, minute_d, second_d;
	logic [iso8601_pkg::MILLI_W-1:0]       milli_d;
	logic                                  accept;

	assign chars.ready = job_ready;
	assign accept      = chars.valid && job_ready;

	assign is_digit = (chars.ch >= 8'h30) && (chars.ch <= 8'h39);
	assign dv       = is_digit ? 4'(chars.ch - 8'h30) : 4'd0;

	// Classify the character by its place and fold digits into their field
	always_comb begin
		err_d    = err_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		milli_d  = milli_q;
		pos_d    = (pos_q < POS_SAT) ? pos_q + 5'd1 : pos_q;
		priority if (pos_q >= POS_LEN) begin
			err_d = 1'b1;
		end else if (pos_q == POS_DASH1 || pos_q == POS_DASH2) begin
			if (chars.ch != 8'h2D) err_d = 1'b1;
		end else if (pos_q == POS_T) begin
			if (chars.ch != 8'h54) err_d = 1'b1;
		end else if (pos_q == POS_COLON1 || pos_q == POS_COLON2) begin
			if (chars.ch != 8'h3A) err_d = 1'b1;
		end else if (pos_q == POS_DOT) begin
			if (chars.ch != 8'h2E) err_d = 1'b1;
		end else if (pos_q == POS_Z) begin
			if (chars.ch != 8'h5A) err_d = 1'b1;
		end else if (!is_digit) begin
			err_d = 1'b1;
		end else if (pos_q < POS_DASH1) begin
			year_d = year_q * 14'd10 + 14'(dv);
		end else if (pos_q < POS_DASH2) begin
			month_d = month_q * 7'd10 + 7'(dv);
		end else if (pos_q < POS_T) begin
			day_d = day_q * 7'd10 + 7'(dv);
		end else if (pos_q < POS_COLON1) begin
			hour_d = hour_q * 7'd10 + 7'(dv);
		end else if (pos_q < POS_COLON2) begin
			minute_d = minute_q * 7'd10 + 7'(dv);
		end else if (pos_q < POS_DOT) begin
			second_d = second_q * 7'd10 + 7'(dv);
		end else begin
			milli_d = milli_q * 10'd10 + 10'(dv);
		end
	end

	// Hand the finished fields to the queue on the last character
	assign job_valid     = chars.valid && chars.last && job_ready;
	assign job.fmt_ok    = !err_d && (pos_d == POS_LEN);
	assign job.year      = year_d;
	assign job.month     = month_d;
	assign job.day       = day_d;
	assign job.hour      = hour_d;
	assign job.minute    = minute_d;
	assign job.second    = second_d;
	assign job.milli     = milli_d;

	// Advance per character; clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			err_q    <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			milli_q  <= '0;
		end else if (accept) begin
			if (chars.last) begin
				pos_q    <= '0;
				err_q    <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				milli_q  <= '0;
			end else begin
				pos_q    <= pos_d;
				err_q    <= err_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
				milli_q  <= milli_d;
			end
		end
	end

endmodule

FILE: sv/iso8601_queue.sv
// Two-entry queue of parsed jobs between the parser and the epoch engine.
// Depends on iso8601_pkg for the job type.
module iso8601_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  iso8601_pkg::job_t    push_job,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output iso8601_pkg::job_t    pop_job
);

	iso8601_pkg::job_t  mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store incoming jobs
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: sv/iso8601_back.sv
// Epoch engine: range checks and Gregorian day count of one job, then scaling to ms.
// Depends on iso8601_pkg, iso8601_res_if and iso8601_cfg_if; holds the year range registers.
module iso8601_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  iso8601_pkg::job_t    job,
	iso8601_res_if.source        res,
	iso8601_cfg_if.sink          cfg
);

	// Reciprocals: x/400 and x/100 for 14-bit x, x/100 for x below 400
	localparam logic [13:0] RECIP_400    = 14'd10486;
	localparam int          SHIFT_400    = 22;
	localparam logic [13:0] RECIP_100    = 14'd10486;
	localparam int          SHIFT_100    = 20;
	localparam logic [14:0] RECIP_100_S  = 15'd41;

	iso8601_pkg::back_state_t  state_q, state_d;

	logic [iso8601_pkg::YEAR_W-1:0]  year_min_q, year_max_q;
	iso8601_pkg::job_t               job_q;
	logic [13:0]                     yy_q;
	logic [27:0]                     era_prod_q, q100_prod_q;
	logic [5:0]                      era_q;
	logic [8:0]                      yoe_q;
	logic [14:0]                     yoe100_prod_q;
	logic [8:0]                      doy_q;
	logic                            ok_q;
	logic [17:0]                     doe_q;
	logic [23:0]                     era_days_q;
	logic [21:0]                     days_q;
	logic [16:0]                     hms_q;
	logic [37:0]                     secs_q;
	logic                            res_valid_q;
	logic                            res_ok_q;
	logic [iso8601_pkg::MS_W-1:0]    res_ms_q;

	logic                            out_free;
	logic                            load_res;
	logic [5:0]                      era_w;
	logic [7:0]                      q100_w;
	logic [13:0]                     r100_w, yoe_w;
	logic                            leap_w;
	logic [4:0]                      mlen_w;
	logic [3:0]                      mp_w;
	logic                            ok_w;
	logic [iso8601_pkg::MS_W-1:0]    ms_w;

	assign cfg.ready = 1'b1;
	assign res.valid     = res_valid_q;
	assign res.valid_res = res_ok_q;
	assign res.epoch_ms  = res_ms_q;
	assign out_free      = !res_valid_q || res.ready;

	// Sequencer: next state and handshake strobes
	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		load_res  = 1'b0;
		unique case (state_q)
			iso8601_pkg::ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) state_d = iso8601_pkg::ST_DIV;
			end
			iso8601_pkg::ST_DIV:   state_d = iso8601_pkg::ST_CHECK;
			iso8601_pkg::ST_CHECK: state_d = iso8601_pkg::ST_DOE;
			iso8601_pkg::ST_DOE:   state_d = iso8601_pkg::ST_DAYS;
			iso8601_pkg::ST_DAYS:  state_d = iso8601_pkg::ST_SECS;
			iso8601_pkg::ST_SECS:  state_d = iso8601_pkg::ST_MS;
			iso8601_pkg::ST_MS: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = iso8601_pkg::ST_IDLE;
				end
			end
			default: state_d = iso8601_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iso8601_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Range checks, leap rule and day-of-year
	assign era_w  = era_prod_q[SHIFT_400 +: 6];
	assign q100_w = q100_prod_q[SHIFT_100 +: 8];
	assign r100_w = job_q.year - 14'({6'd0, q100_w} * 14'd100);
	assign yoe_w  = yy_q - 14'({8'd0, era_w} * 14'd400);
	assign leap_w = ((job_q.year[1:0] == 2'd0) && (r100_w != 14'd0))
		|| ((r100_w == 14'd0) && (q100_w[1:0] == 2'd0));
	assign mlen_w = iso8601_pkg::month_days(job_q.month[3:0], leap_w);
	assign mp_w   = (job_q.month > 7'd2) ? 4'(job_q.month - 7'd3) : 4'(job_q.month + 7'd9);
	assign ok_w   = job_q.fmt_ok
		&& (job_q.year >= iso8601_pkg::EPOCH_YEAR)
		&& (job_q.year >= year_min_q) && (job_q.year <= year_max_q)
		&& (job_q.month >= 7'd1) && (job_q.month <= 7'd12)
		&& (job_q.day >= 7'd1) && (job_q.day <= {2'd0, mlen_w})
		&& (job_q.hour <= 7'd23) && (job_q.minute <= 7'd59) && (job_q.second <= 7'd59);

	// Scale seconds by 1000 as 1024 - 16 - 8
	assign ms_w = {secs_q, 10'd0} - {6'd0, secs_q, 4'd0} - {7'd0, secs_q, 3'd0}
		+ {38'd0, job_q.milli};

	// Step the conversion datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			iso8601_pkg::ST_IDLE: begin
				if (job_valid) job_q <= job;
			end
			iso8601_pkg::ST_DIV: begin
				yy_q        <= job_q.year - ((job_q.month <= 7'd2) ? 14'd1 : 14'd0);
				era_prod_q  <= 28'(job_q.year - ((job_q.month <= 7'd2) ? 14'd1 : 14'd0))
					* 28'(RECIP_400);
				q100_prod_q <= 28'(job_q.year) * 28'(RECIP_100);
			end
			iso8601_pkg::ST_CHECK: begin
				era_q         <= era_w;
				yoe_q         <= yoe_w[8:0];
				yoe100_prod_q <= 15'(yoe_w[8:0]) * RECIP_100_S;
				doy_q         <= iso8601_pkg::month_start(mp_w) + 9'(job_q.day) - 9'd1;
				ok_q          <= ok_w;
			end
			iso8601_pkg::ST_DOE: begin
				doe_q      <= 18'(yoe_q) * 18'd365 + 18'(yoe_q[8:2])
					- 18'(yoe100_prod_q[14:12]) + 18'(doy_q);
				era_days_q <= 24'(era_q) * 24'd146097;
			end
			iso8601_pkg::ST_DAYS: begin
				days_q <= 22'(25'(era_days_q) + 25'(doe_q) - 25'd719468);
				hms_q  <= 17'(19'(job_q.hour) * 19'd3600 + 19'(job_q.minute) * 19'd60
					+ 19'(job_q.second));
			end
			iso8601_pkg::ST_SECS: begin
				secs_q <= 38'(days_q) * 38'd86400 + 38'(hms_q);
			end
			default: begin
			end
		endcase
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_ok_q <= ok_q;
			res_ms_q <= ok_q ? ms_w : '0;
		end
	end

	// Year range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_min_q <= iso8601_pkg::YEAR_MIN_RST;
			year_max_q <= iso8601_pkg::YEAR_MAX_RST;
		end else if (cfg.valid) begin
			if (cfg.index == iso8601_pkg::CFG_YEAR_MIN) year_min_q <= cfg.data;
			if (cfg.index == iso8601_pkg::CFG_YEAR_MAX) year_max_q <= cfg.data;
		end
	end

endmodule

FILE: sv/iso8601_utc_to_epoch_ms_top.sv
// ISO 8601 UTC timestamp to Unix epoch milliseconds, top level.
// Depends on iso8601_pkg, iso8601_if, iso8601_front, iso8601_queue and iso8601_back.
//
// Usage:
//   chars: one character per item (ch, last), last marks the final character.
//          A character is taken every cycle while the job queue has room.
//   res:   one item per string: valid_res and epoch_ms (zero when invalid).
//          A string is valid only as YYYY-MM-DDTHH:MM:SS.mmmZ, 24 characters,
//          with every field in range and the year within year_min..year_max.
//   cfg:   register writes, index 0 year_min, index 1 year_max; always ready.
//          Write only while no string is in flight.
// Throughput: one character per cycle while the job queue has room. The epoch
//   engine takes one string at a time (a load step, then six sequencer steps:
//   reciprocal divides, checks, day count, seconds, milliseconds); a two-entry
//   queue sits in front of it. Path: a string's job passes through the queue
//   and the states IDLE, DIV, CHECK, DOE, DAYS, SECS and MS into the result
//   register when the output is free; a queued string waits for those ahead.
// Reset: clears parser, queue and sequencer; year_min 2024, year_max 2100.
// Stall: a held result blocks the engine's final step; the queue then fills
//   and chars.ready drops until the receiver takes the result.
module iso8601_utc_to_epoch_ms_top (
	input  logic            clk,
	input  logic            arst_n,
	iso8601_char_if.sink    chars,
	iso8601_res_if.source   res,
	iso8601_cfg_if.sink     cfg
);

	logic                 push_valid, push_ready;
	iso8601_pkg::job_t    push_job;
	logic                 pop_valid, pop_ready;
	iso8601_pkg::job_t    pop_job;

	iso8601_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job       (push_job)
	);

	iso8601_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	iso8601_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.res       (res),
		.cfg       (cfg)
	);

endmodule

FILE: tb/sv/tb_iso8601_check_pkg.sv
`timescale 1ns / 100ps
// Expected-result predictor for the ISO 8601 to epoch-milliseconds block.
// Tracks the per-character parse state and the year window, queues one result per string.
// Depends on iso8601_pkg for field widths and register indexes.
package tb_iso8601_check_pkg;
	import iso8601_pkg::*;

	typedef struct {
		logic            valid_res;
		logic [MS_W-1:0] epoch_ms;
	} epoch_item_t;

	class epoch_ms_predictor;
		logic [YEAR_W-1:0]  year_lo;
		logic [YEAR_W-1:0]  year_hi;
		logic [4:0]         pos;
		logic               fmt_err;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
		logic [MILLI_W-1:0] milli;
		epoch_item_t        expected_epochs[$];
		int                 error_count;

		function new();
			year_lo = YEAR_MIN_RST;
			year_hi = YEAR_MAX_RST;
			error_count = 0;
			clear_fields();
		endfunction

		function void clear_fields();
			pos = '0;
			fmt_err = 1'b0;
			year = '0;
			month = '0;
			day = '0;
			hour = '0;
			minute = '0;
			second = '0;
			milli = '0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [YEAR_W-1:0] val);
			if (idx == CFG_YEAR_MIN) begin
				year_lo = val;
			end else if (idx == CFG_YEAR_MAX) begin
				year_hi = val;
			end
		endfunction

		function bit is_leap(int unsigned y);
			return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
		endfunction

		function int unsigned days_in(int unsigned y, int unsigned m);
			case (m)
				2: begin
					return is_leap(y) ? 29 : 28;
				end
				4, 6, 9, 11: begin
					return 30;
				end
				default: begin
					return 31;
				end
			endcase
		endfunction

		// Range-check the gathered fields and convert them to epoch milliseconds
		function epoch_item_t predict();
			epoch_item_t       r;
			longint unsigned   y, m, d, yy, era, yoe, mp, doy, doe, days, secs;
			y = year;
			m = month;
			d = day;
			r.valid_res = !fmt_err && pos == 24;
			if (r.valid_res && (y < EPOCH_YEAR || y < year_lo || y > year_hi ||
					m < 1 || m > 12 || d < 1 || d > days_in(32'(y), 32'(m)) ||
					hour > 23 || minute > 59 || second > 59)) begin
				r.valid_res = 1'b0;
			end
			r.epoch_ms = '0;
			if (r.valid_res) begin
				// Count days from a March-based year, then shift to 1970-01-01
				yy = y - ((m <= 2) ? 1 : 0);
				era = yy / 400;
				yoe = yy - era * 400;
				mp = (m > 2) ? m - 3 : m + 9;
				doy = (153 * mp + 2) / 5 + d - 1;
				doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
				days = era * 146097 + doe - 719468;
				secs = days * 86400 + hour * 3600 + minute * 60 + second;
				r.epoch_ms = MS_W'(secs * 1000 + milli);
			end
			return r;
		endfunction

		// Note one accepted character; a marked one closes the string
		function void take_char(logic [7:0] c, logic is_last);
			logic       dig;
			logic [3:0] dv;
			dig = (c >= "0" && c <= "9");
			dv = dig ? 4'(c - "0") : 4'd0;
			if (pos >= 24) begin
				fmt_err = 1'b1;
			end else if (pos == 4 || pos == 7) begin
				if (c != "-") fmt_err = 1'b1;
			end else if (pos == 10) begin
				if (c != "T") fmt_err = 1'b1;
			end else if (pos == 13 || pos == 16) begin
				if (c != ":") fmt_err = 1'b1;
			end else if (pos == 19) begin
				if (c != ".") fmt_err = 1'b1;
			end else if (pos == 23) begin
				if (c != "Z") fmt_err = 1'b1;
			end else if (!dig) begin
				fmt_err = 1'b1;
			end else if (pos < 4) begin
				year = YEAR_W'(year * 10 + dv);
			end else if (pos < 7) begin
				month = FIELD_W'(month * 10 + dv);
			end else if (pos < 10) begin
				day = FIELD_W'(day * 10 + dv);
			end else if (pos < 13) begin
				hour = FIELD_W'(hour * 10 + dv);
			end else if (pos < 16) begin
				minute = FIELD_W'(minute * 10 + dv);
			end else if (pos < 19) begin
				second = FIELD_W'(second * 10 + dv);
			end else begin
				milli = MILLI_W'(milli * 10 + dv);
			end
			if (pos < 25) pos++;
			if (is_last) begin
				expected_epochs.push_back(predict());
				clear_fields();
			end
		endfunction

		// Compare one accepted result against the oldest pending string
		function void check_result(logic v, logic [MS_W-1:0] e);
			epoch_item_t want;
			if (expected_epochs.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual valid_res %0d epoch_ms %0d",
					$time, v, e);
				return;
			end
			want = expected_epochs.pop_front();
			if (v !== want.valid_res) begin
				error_count++;
				$display("%0t: valid_res mismatch, expected %0d, actual %0d",
					$time, want.valid_res, v);
			end
			if (e !== want.epoch_ms) begin
				error_count++;
				$display("%0t: epoch_ms mismatch, expected %0d, actual %0d",
					$time, want.epoch_ms, e);
			end
		endfunction
	endclass

endpackage

FILE: tb/sv/tb_iso8601_utc_to_epoch_ms_top.sv
`timescale 1ns / 100ps
// Regression bench for iso8601_utc_to_epoch_ms_top: directed timestamps, then random strings.
// Depends on iso8601_pkg, iso8601_if, tb_iso8601_check_pkg and the block's RTL.
module tb_iso8601_utc_to_epoch_ms_top;
	import iso8601_pkg::*;
	import tb_iso8601_check_pkg::*;

	localparam int CYCLE_LIMIT       = 200000;
	localparam int SETTLE_CYCLES     = 12;
	localparam int STRINGS_PER_PHASE = 10;
	localparam int YEAR_DIGIT_MAX    = 9999;

	// Idle percentages per pass: sender light, then receiver light, then none
	localparam int SRC_IDLE [0:2] = '{33, 76, 0};
	localparam int SNK_IDLE [0:2] = '{76, 33, 0};

	logic        clk;
	logic        arst_n;
	int          src_idle_pct = SRC_IDLE[0];
	int          snk_idle_pct = SNK_IDLE[0];
	int unsigned cycle_count = 0;
	logic [7:0]  stamp [0:31];
	int          stamp_len;

	epoch_ms_predictor epoch_pred;

	iso8601_char_if chars();
	iso8601_res_if  res();
	iso8601_cfg_if  cfg();

	iso8601_utc_to_epoch_ms_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (chars),
		.res   (res),
		.cfg   (cfg)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("iso8601_utc_to_epoch_ms_top regression: fail");
			$finish;
		end
	end

	// Take results with random back-pressure
	initial begin
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				epoch_pred.check_result(res.valid_res, res.epoch_ms);
			end
			res.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Offer one character, hold it until taken
	task automatic send_char(logic [7:0] c, logic is_last);
		if ($urandom_range(99) < src_idle_pct) begin
			chars.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		chars.valid <= 1'b1;
		chars.ch <= c;
		chars.last <= is_last;
		do @(posedge clk); while (!chars.ready);
		epoch_pred.take_char(c, is_last);
	endtask

	task automatic send_stamp(logic with_last);
		for (int i = 0; i < stamp_len; i++) begin
			send_char(stamp[i], with_last && (i == stamp_len - 1));
		end
	endtask

	task automatic send_text(string s, logic with_last = 1'b1);
		stamp_len = s.len();
		for (int i = 0; i < stamp_len; i++) stamp[i] = s[i];
		send_stamp(with_last);
	endtask

	// Drop valid and wait for every pending string to come back
	task automatic drain();
		chars.valid <= 1'b0;
		while (epoch_pred.expected_epochs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [YEAR_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		epoch_pred.set_register(idx, val);
		@(posedge clk);
	endtask

	task automatic set_years(int unsigned lo, int unsigned hi);
		drain();
		write_reg(CFG_YEAR_MIN, YEAR_W'(lo));
		write_reg(CFG_YEAR_MAX, YEAR_W'(hi));
	endtask

	function automatic int unsigned pick_field(int unsigned lo, int unsigned hi);
		return ($urandom_range(99) < 85) ? $urandom_range(hi, lo) : $urandom_range(99);
	endfunction

	// Build a mostly well-formed timestamp, sometimes corrupted, resized or pure noise
	function automatic void build_random_stamp();
		int unsigned y, m, d, h, mi, s, ms, dmax, top, r, kind, extra;
		string       txt;
		top = (epoch_pred.year_hi > YEAR_DIGIT_MAX) ? YEAR_DIGIT_MAX : epoch_pred.year_hi;
		if ($urandom_range(99) < 70 && epoch_pred.year_lo <= top) begin
			y = $urandom_range(top, epoch_pred.year_lo);
		end else begin
			y = $urandom_range(YEAR_DIGIT_MAX);
		end
		m = pick_field(1, 12);
		dmax = epoch_pred.days_in(y, m);
		r = $urandom_range(99);
		if (r < 70) begin
			d = $urandom_range(dmax, 1);
		end else if (r < 85) begin
			d = dmax + $urandom_range(1);
		end else begin
			d = $urandom_range(99);
		end
		h = pick_field(0, 23);
		mi = pick_field(0, 59);
		s = pick_field(0, 59);
		ms = $urandom_range(999);
		txt = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d.%03dZ", y, m, d, h, mi, s, ms);
		stamp_len = 24;
		for (int i = 0; i < 24; i++) stamp[i] = txt[i];
		kind = $urandom_range(99);
		if (kind >= 70 && kind < 85) begin
			stamp[$urandom_range(23)] = 8'($urandom_range(255));
		end else if (kind >= 85 && kind < 93) begin
			if ($urandom_range(1)) begin
				stamp_len = $urandom_range(23, 1);
			end else begin
				extra = $urandom_range(4, 1);
				for (int i = 24; i < 24 + extra; i++) stamp[i] = 8'($urandom_range(255));
				stamp_len = 24 + extra;
			end
		end else if (kind >= 93) begin
			stamp_len = $urandom_range(30, 1);
			for (int i = 0; i < stamp_len; i++) stamp[i] = 8'($urandom_range(255));
		end
	endfunction

	initial begin
		int unsigned lo, hi;
		epoch_pred = new();
		arst_n <= 1'b0;
		chars.valid <= 1'b0;
		chars.ch <= '0;
		chars.last <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_YEAR_MIN;
		cfg.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window: leap day, non-leap century, both year bounds
		send_text("2024-02-29T12:34:56.789Z");
		send_text("2100-02-29T00:00:00.000Z");
		send_text("2023-12-31T23:59:59.999Z");
		send_text("2101-01-01T00:00:00.000Z");

		// Full window: extremes, field ranges, layout errors
		set_years(EPOCH_YEAR, YEAR_DIGIT_MAX);
		send_text("1970-01-01T00:00:00.000Z");
		send_text("9999-12-31T23:59:59.999Z");
		send_text("2000-02-29T23:59:59.999Z");
		send_text("1999-02-29T00:00:00.000Z");
		send_text("2024-04-31T00:00:00.000Z");
		send_text("2024-00-10T00:00:00.000Z");
		send_text("2024-13-10T00:00:00.000Z");
		send_text("2024-05-00T00:00:00.000Z");
		send_text("2024-05-10T24:00:00.000Z");
		send_text("2024-05-10T23:60:00.000Z");
		send_text("2024-05-10T23:59:60.000Z");
		send_text("2024-05-10T23:59:59.000");
		send_text("2024-05-10T23:59:59.000ZZ");
		send_text("2024/05-10T23:59:59.000Z");
		send_text("2024-05-10 23:59:59.000Z");
		send_text("2024-05-1aT23:59:59.000Z");
		send_text("2024-05-10T23:59:59.000z");
		send_text("Z");
		// Unmarked characters give nothing until the string closes
		send_text("2024-05", 1'b0);
		send_text("-10T23:59:59.000Z");

		// Open window: years before the epoch still fail
		set_years(0, 16383);
		send_text("1969-12-31T23:59:59.999Z");
		send_text("0000-01-01T00:00:00.000Z");

		// Inverted window accepts nothing
		set_years(3000, 2000);
		send_text("2500-06-15T08:00:00.000Z");

		// Random strings across idle patterns and year windows
		for (int mode = 0; mode < 3; mode++) begin
			for (int ph = 0; ph < 2; ph++) begin
				case ($urandom_range(3))
					0: begin
						lo = EPOCH_YEAR;
						hi = YEAR_DIGIT_MAX;
					end
					1: begin
						lo = YEAR_MIN_RST;
						hi = YEAR_MAX_RST;
					end
					2: begin
						lo = $urandom_range(YEAR_DIGIT_MAX, EPOCH_YEAR);
						hi = $urandom_range(YEAR_DIGIT_MAX, lo);
					end
					default: begin
						lo = $urandom_range(YEAR_DIGIT_MAX, EPOCH_YEAR + 1);
						hi = $urandom_range(lo - 1, EPOCH_YEAR);
					end
				endcase
				set_years(lo, hi);
				src_idle_pct = SRC_IDLE[mode];
				snk_idle_pct = SNK_IDLE[mode];
				for (int n = 0; n < STRINGS_PER_PHASE; n++) begin
					build_random_stamp();
					send_stamp(1'b1);
				end
			end
		end

		drain();
		if (epoch_pred.error_count == 0 && epoch_pred.expected_epochs.size() == 0) begin
			$display("iso8601_utc_to_epoch_ms_top regression: pass");
		end else begin
			$display("iso8601_utc_to_epoch_ms_top regression: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/iso8601_pkg.sv
sv/iso8601_if.sv
sv/iso8601_front.sv
sv/iso8601_queue.sv
sv/iso8601_back.sv
sv/iso8601_utc_to_epoch_ms_top.sv
tb/sv/tb_iso8601_check_pkg.sv
tb/sv/tb_iso8601_utc_to_epoch_ms_top.sv
